@@ rtl/rps_pkg.sv @@
// shared types and character constants for the pre-token splitter
`default_nettype none

package rps_pkg;

	localparam int CP_W     = 21;
	localparam int LA_DEPTH = 3;

	typedef logic [CP_W-1:0] cp_t;

	// input item as it crosses the item channel
	typedef struct packed {
		cp_t  codepoint;
		logic letter_flag;
		logic digit_flag;
		logic space_flag;
		logic text_end;
	} item_t;

	// one released codepoint on the result channel
	typedef struct packed {
		cp_t  out_codepoint;
		logic piece_start;
		logic text_final;
		logic batch_last;
	} result_t;

	// held lookahead entry
	typedef struct packed {
		logic letter;
		logic digit;
		logic space;
		cp_t  cp;
	} ent_t;

	typedef enum logic [1:0] {
		CLS_L,
		CLS_D,
		CLS_W,
		CLS_P
	} cls_t;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_LETTER,
		MODE_PUNCT,
		MODE_PUNCT_NL,
		MODE_WS,
		MODE_CONTR1,
		MODE_CONTR2
	} mode_t;

	// splitter state carried between items
	typedef struct packed {
		ent_t [LA_DEPTH-1:0] ent;
		logic [1:0]          held;
		mode_t               mode;
	} la_state_t;

	// one release of a step
	typedef struct packed {
		cp_t  cp;
		logic st;
	} rel_t;

	// everything one item releases
	typedef struct packed {
		rel_t [LA_DEPTH-1:0] rel;
		logic [1:0]          cnt;
	} step_res_t;

	localparam cp_t CH_APOS     = 21'h27;
	localparam cp_t CH_S        = 21'h73;
	localparam cp_t CH_T        = 21'h74;
	localparam cp_t CH_M        = 21'h6d;
	localparam cp_t CH_D        = 21'h64;
	localparam cp_t CH_R        = 21'h72;
	localparam cp_t CH_V        = 21'h76;
	localparam cp_t CH_L        = 21'h6c;
	localparam cp_t CH_E        = 21'h65;
	localparam cp_t CH_UA       = 21'h41;
	localparam cp_t CH_UZ       = 21'h5a;
	localparam cp_t CH_CR       = 21'h0d;
	localparam cp_t CH_LF       = 21'h0a;
	localparam cp_t CH_SP       = 21'h20;
	localparam cp_t CASE_OFFSET = 21'd32;

endpackage

`default_nettype wire

@@ rtl/rps_step.sv @@
// combinational step: append one codepoint and release what the rules allow
`default_nettype none

module rps_step (
	input  wire rps_pkg::la_state_t cur,
	input  wire rps_pkg::item_t     item,
	output rps_pkg::la_state_t      nxt,
	output rps_pkg::step_res_t      res
);

	typedef struct packed {
		logic           go;
		logic           st;
		rps_pkg::mode_t nm;
	} dec_t;

	function automatic rps_pkg::cls_t cls_of(rps_pkg::ent_t e);
		rps_pkg::cls_t c;
		if (e.letter)
			c = rps_pkg::CLS_L;
		else if (e.digit)
			c = rps_pkg::CLS_D;
		else if (e.space)
			c = rps_pkg::CLS_W;
		else
			c = rps_pkg::CLS_P;
		return c;
	endfunction

	function automatic logic is_crlf(rps_pkg::cp_t cp);
		return (cp == rps_pkg::CH_CR) || (cp == rps_pkg::CH_LF);
	endfunction

	function automatic rps_pkg::cp_t fold(rps_pkg::cp_t cp);
		rps_pkg::cp_t r;
		if (cp >= rps_pkg::CH_UA && cp <= rps_pkg::CH_UZ)
			r = cp + rps_pkg::CASE_OFFSET;
		else
			r = cp;
		return r;
	endfunction

	// head entry opens a new piece
	function automatic dec_t start_decide(rps_pkg::la_state_t s, logic fin);
		dec_t          d;
		rps_pkg::cp_t  cp;
		rps_pkg::cp_t  y;
		rps_pkg::cp_t  z;
		rps_pkg::cls_t cx;
		rps_pkg::cls_t cy;
		logic          h1;
		logic          h2;
		logic          w1;
		logic          w2;
		d.go = 1'b1;
		d.st = 1'b1;
		d.nm = rps_pkg::MODE_START;
		cp = s.ent[0].cp;
		cx = cls_of(s.ent[0]);
		cy = cls_of(s.ent[1]);
		y  = fold(s.ent[1].cp);
		z  = fold(s.ent[2].cp);
		h1 = s.held > 2'd1;
		h2 = s.held > 2'd2;
		w1 = !h1 && !fin;
		w2 = !h2 && !fin;
		if (cp == rps_pkg::CH_APOS) begin
			if (w1) begin
				d.go = 1'b0;
				return d;
			end
			if (h1) begin
				if (y == rps_pkg::CH_S || y == rps_pkg::CH_T ||
				    y == rps_pkg::CH_M || y == rps_pkg::CH_D) begin
					d.nm = rps_pkg::MODE_CONTR1;
					return d;
				end
				if (y == rps_pkg::CH_R || y == rps_pkg::CH_V || y == rps_pkg::CH_L) begin
					if (w2) begin
						d.go = 1'b0;
						return d;
					end
					if (h2 && ((((y == rps_pkg::CH_R) || (y == rps_pkg::CH_V)) &&
					            z == rps_pkg::CH_E) ||
					           (y == rps_pkg::CH_L && z == rps_pkg::CH_L))) begin
						d.nm = rps_pkg::MODE_CONTR2;
						return d;
					end
				end
			end
		end
		if (cx == rps_pkg::CLS_L) begin
			d.nm = rps_pkg::MODE_LETTER;
			return d;
		end
		if (cx == rps_pkg::CLS_D) begin
			d.nm = rps_pkg::MODE_START;
			return d;
		end
		if (!is_crlf(cp)) begin
			if (w1) begin
				d.go = 1'b0;
				return d;
			end
			if (h1) begin
				if (cy == rps_pkg::CLS_L) begin
					d.nm = rps_pkg::MODE_LETTER;
					return d;
				end
				if (cp == rps_pkg::CH_SP && cy == rps_pkg::CLS_P) begin
					d.nm = rps_pkg::MODE_PUNCT;
					return d;
				end
			end
		end
		d.nm = (cx == rps_pkg::CLS_P) ? rps_pkg::MODE_PUNCT : rps_pkg::MODE_WS;
		return d;
	endfunction

	// head entry under the open piece
	function automatic dec_t decide(rps_pkg::la_state_t s, logic fin);
		dec_t          d;
		rps_pkg::cp_t  cp;
		rps_pkg::cls_t cx;
		rps_pkg::cls_t cz;
		logic          donate;
		d.go   = 1'b1;
		d.st   = 1'b0;
		d.nm   = rps_pkg::MODE_START;
		cp     = s.ent[0].cp;
		cx     = cls_of(s.ent[0]);
		cz     = cls_of(s.ent[1]);
		donate = (s.held > 2'd1) &&
		         ((cz == rps_pkg::CLS_L && !is_crlf(cp)) ||
		          (cz == rps_pkg::CLS_P && cp == rps_pkg::CH_SP));
		case (s.mode)
			rps_pkg::MODE_CONTR2: begin
				d.nm = rps_pkg::MODE_CONTR1;
				return d;
			end
			rps_pkg::MODE_CONTR1: begin
				d.nm = rps_pkg::MODE_START;
				return d;
			end
			rps_pkg::MODE_LETTER: begin
				if (cx == rps_pkg::CLS_L) begin
					d.nm = rps_pkg::MODE_LETTER;
					return d;
				end
			end
			rps_pkg::MODE_PUNCT: begin
				if (cx == rps_pkg::CLS_P) begin
					d.nm = rps_pkg::MODE_PUNCT;
					return d;
				end
				if (is_crlf(cp)) begin
					d.nm = rps_pkg::MODE_PUNCT_NL;
					return d;
				end
			end
			rps_pkg::MODE_PUNCT_NL: begin
				if (is_crlf(cp)) begin
					d.nm = rps_pkg::MODE_PUNCT_NL;
					return d;
				end
			end
			rps_pkg::MODE_WS: begin
				if (cx == rps_pkg::CLS_W) begin
					// need the next char to know if the last space is handed on
					if (!(s.held > 2'd1) && !fin) begin
						d.go = 1'b0;
						return d;
					end
					if (!donate) begin
						d.nm = rps_pkg::MODE_WS;
						return d;
					end
				end
			end
			default: begin
			end
		endcase
		return start_decide(s, fin);
	endfunction

	always_comb begin
		rps_pkg::la_state_t s;
		rps_pkg::step_res_t r;
		rps_pkg::ent_t      e;
		dec_t               d;
		logic               run;
		e.letter = item.letter_flag;
		e.digit  = item.digit_flag;
		e.space  = item.space_flag;
		e.cp     = item.codepoint;
		s = cur;
		case (cur.held)
			2'd0:    s.ent[0] = e;
			2'd1:    s.ent[1] = e;
			default: s.ent[2] = e;
		endcase
		s.held = cur.held + 2'd1;
		r      = '0;
		run    = 1'b1;
		d      = '0;
		for (int k = 0; k < rps_pkg::LA_DEPTH; k++) begin
			if (run && s.held != 2'd0) begin
				d = decide(s, item.text_end);
				if (d.go) begin
					r.rel[k].cp = s.ent[0].cp;
					r.rel[k].st = d.st;
					r.cnt       = r.cnt + 2'd1;
					s.ent       = {rps_pkg::ent_t'('0), s.ent[rps_pkg::LA_DEPTH-1:1]};
					s.held      = s.held - 2'd1;
					s.mode      = d.nm;
				end else begin
					run = 1'b0;
				end
			end else begin
				run = 1'b0;
			end
		end
		// end of text flushes everything and closes the piece
		if (item.text_end)
			s = '0;
		nxt = s;
		res = r;
	end

endmodule

`default_nettype wire

@@ rtl/regex_pretokenizer_splitter.sv @@
// top level of the streaming pre-token splitter
`default_nettype none

// Splits a codepoint stream into pre-token pieces. Each accepted item is one
// codepoint with its letter, digit and whitespace flags; every codepoint comes
// back out once, in order, with piece_start set on the first codepoint of a
// piece. Rules at each piece start, in order: ASCII contractions ('s 't 'm 'd
// 're 've 'll, any case), an optional one-character lead plus a letter run, a
// single digit, an optional space plus a punctuation run plus trailing CR/LF,
// and a whitespace run whose last character moves to the next piece when that
// piece can use it as a lead. Up to two codepoints are held as lookahead, so a
// codepoint may leave only after one or two later ones arrive; text_end on an
// item releases everything held and starts a fresh text. Results of one item
// are a batch of zero to three transfers; batch_last marks its final transfer
// and text_final marks the final transfer of a text. An item passes through the
// input register, then the step logic updates the lookahead and loads the
// result register. The result register sends one transfer per cycle while
// result_stall is low, so an item that releases several codepoints holds back
// the next item until the last transfer of its batch goes; with the usual one
// release per item the block takes one item every cycle while results flow.
module regex_pretokenizer_splitter (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  wire rps_pkg::item_t  item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output rps_pkg::result_t     result
);

	// input register
	logic           valid_s1;
	rps_pkg::item_t item_s1;

	// lookahead and open piece
	rps_pkg::la_state_t state_q;
	rps_pkg::la_state_t state_nxt;
	rps_pkg::step_res_t step_res;

	// result batch register
	rps_pkg::rel_t [rps_pkg::LA_DEPTH-1:0] rel_q;
	logic [1:0] rem_q;
	logic [1:0] ptr_q;
	logic       fin_q;

	logic out_xfer;
	logic batch_free;
	logic advance;

	rps_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (step_res)
	);

	assign out_xfer   = result_valid && !result_stall;
	// the batch register can take a new batch when it is empty or empties this cycle
	assign batch_free = (rem_q == 2'd0) || (rem_q == 2'd1 && out_xfer);
	assign advance    = valid_s1 && batch_free;
	assign item_stall = valid_s1 && !batch_free;

	// input register: loads whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// splitter state moves once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// batch bookkeeping: a new batch (possibly empty) replaces the drained one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			ptr_q <= 2'd0;
			fin_q <= 1'b0;
		end else if (advance) begin
			rem_q <= step_res.cnt;
			ptr_q <= 2'd0;
			fin_q <= item_s1.text_end;
		end else if (out_xfer) begin
			rem_q <= rem_q - 2'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rel_q <= step_res.rel;
		end
	end

	// output side reads the current entry of the batch
	assign result_valid         = (rem_q != 2'd0);
	assign result.out_codepoint = rel_q[ptr_q].cp;
	assign result.piece_start   = rel_q[ptr_q].st;
	assign result.batch_last    = (rem_q == 2'd1);
	assign result.text_final    = fin_q && (rem_q == 2'd1);

	// lookahead never holds more than two codepoints between items
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held != 2'd3)
		else $error("lookahead holds more than two codepoints");

	// end of text leaves nothing held and no open piece
	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.text_end) |=>
		(state_q.held == 2'd0 && state_q.mode == rps_pkg::MODE_START))
		else $error("text end did not flush the lookahead");

	// a two-character contraction tail is still held after its apostrophe
	a_contr_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == rps_pkg::MODE_CONTR2) |-> (state_q.held == 2'd2))
		else $error("contraction tail missing from lookahead");

	// a step at end of text always releases at least one codepoint
	a_end_release: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.text_end) |-> (step_res.cnt != 2'd0))
		else $error("end of text released nothing");

endmodule

`default_nettype wire
